[src/sptd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptd_pkg
// Shared constants and types of the sparse task dispatcher.
// ----------------------------------------------------------------------------
package sptd_pkg;

  localparam int MAX_PES      = 32;
  localparam int MAX_GROUP    = 8;
  localparam int WORK_BITS    = 16;
  localparam int PE_BITS      = $clog2(MAX_PES);
  localparam int PES_BITS     = $clog2(MAX_PES + 1);
  localparam int GIDX_BITS    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int FILL_BITS    = $clog2(MAX_GROUP + 1);
  localparam int GSIZE_BITS   = 4;
  localparam int COL_BITS     = 16;
  localparam int WGT_BITS     = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int PROD_BITS    = WORK_BITS + PES_BITS;

  typedef enum logic [1:0] {
    MODE_THRESH = 2'd0,
    MODE_WRR    = 2'd1,
    MODE_GROUP  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE       = 3'd0,
    CFG_PE_COUNT   = 3'd1,
    CFG_GROUP_SIZE = 3'd2,
    CFG_COL_COUNT  = 3'd3,
    CFG_WEIGHTS_LO = 3'd4,
    CFG_WEIGHTS_HI = 3'd5
  } cfg_idx_t;

  localparam logic [1:0]               MODE_RST   = 2'd1;
  localparam logic [PES_BITS-1:0]      PES_RST    = PES_BITS'(16);
  localparam logic [GSIZE_BITS-1:0]    GSIZE_RST  = GSIZE_BITS'(4);
  localparam logic [COL_BITS-1:0]      COL_RST    = COL_BITS'(64);
  localparam logic [CFG_DATA_BITS-1:0] WGT_RST    = 64'h1111_1111_1111_1111;

endpackage

[src/sptd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptd channel interfaces
// Valid/ready channels for task beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface sptd_task_if;
  import sptd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WORK_BITS-1:0] work;
  logic                 row_end;
  modport source (output valid, work, row_end, input ready);
  modport sink   (input valid, work, row_end, output ready);
endinterface

interface sptd_result_if;
  import sptd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PE_BITS-1:0]   pe_index;
  logic [WORK_BITS-1:0] task_work;
  logic                 dropped;
  logic                 run_last;
  modport source (output valid, pe_index, task_work, dropped, run_last, input ready);
  modport sink   (input valid, pe_index, task_work, dropped, run_last, output ready);
endinterface

interface sptd_cfg_if;
  import sptd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/sparse_task_dispatcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_task_dispatcher
// Assigns task beats to processing elements by threshold band, weighted
// round robin or sorted groups.
// ----------------------------------------------------------------------------
// Path: a threshold or round robin task beat passes the input register and then
//   the result register; a group flush goes through the drain state before it.
// Throughput: one task beat per cycle unless the result register or a drain
//   stalls it; the beat that completes a group of n starts a drain of n results,
//   one per cycle when taken, and in_ch takes one more beat at most, then stalls.
// Reset: synchronous, active low; registers to defaults, pointers cleared.
module sparse_task_dispatcher (
  input  logic          clk,
  input  logic          rst_n,
  sptd_task_if.sink     in_ch,
  sptd_result_if.source out_ch,
  sptd_cfg_if.sink      cfg_ch
);
  import sptd_pkg::*;

  // Configuration registers
  mode_t                     mode_r;
  logic [PES_BITS-1:0]       pe_count_r;
  logic [GSIZE_BITS-1:0]     group_size_r;
  logic [COL_BITS-1:0]       col_count_r;
  logic [2*CFG_DATA_BITS-1:0] weights_r;

  // Input register
  logic                 s1_vld_r, s1_vld_nxt;
  logic [WORK_BITS-1:0] s1_work_r;
  logic                 s1_row_end_r;

  // Result register
  logic                 out_vld_r, out_vld_nxt;
  logic [PE_BITS-1:0]   out_pe_r, out_pe_nxt;
  logic [WORK_BITS-1:0] out_work_r, out_work_nxt;
  logic                 out_drop_r, out_drop_nxt;
  logic                 out_last_r, out_last_nxt;

  // Dispatch state
  logic [PE_BITS-1:0]   rr_element_r, rr_element_nxt;
  logic [WGT_BITS-1:0]  rr_used_r, rr_used_nxt;
  logic [FILL_BITS-1:0] group_fill_r, group_fill_nxt;
  logic [PE_BITS-1:0]   group_element_r, group_element_nxt;
  logic [WORK_BITS-1:0] group_store_r   [MAX_GROUP];
  logic [WORK_BITS-1:0] group_store_nxt [MAX_GROUP];

  // Drain of a completed group
  logic [FILL_BITS-1:0] drain_cnt_r, drain_cnt_nxt;
  logic [GIDX_BITS-1:0] drain_idx_r, drain_idx_nxt;
  logic                 drain_clr_r, drain_clr_nxt;

  // Working signals
  logic                 out_free, s1_take, drain_emit, store_we;
  logic [PES_BITS-1:0]  pes;
  logic [GSIZE_BITS-1:0] gs;
  logic [PROD_BITS-1:0] thr_lhs, thr_rhs;
  logic [MAX_PES-1:0]   thr_hit;
  logic [PE_BITS-1:0]   thr_pe;
  logic                 thr_found;
  logic [PE_BITS-1:0]   rr_cur, rr_step, ge_cur, ge_step;
  logic [WGT_BITS-1:0]  rr_used_cur, rr_used_inc, rr_weight;
  logic [MAX_GROUP-1:0] ins_gt;
  logic [FILL_BITS-1:0] fill_inc;

  // Clamp the register values into their working ranges
  always_comb begin
    if (pe_count_r == '0) begin
      pes = PES_BITS'(1);
    end else if (pe_count_r > PES_BITS'(MAX_PES)) begin
      pes = PES_BITS'(MAX_PES);
    end else begin
      pes = pe_count_r;
    end
    if (group_size_r == '0) begin
      gs = GSIZE_BITS'(1);
    end else if (group_size_r > GSIZE_BITS'(MAX_GROUP)) begin
      gs = GSIZE_BITS'(MAX_GROUP);
    end else begin
      gs = group_size_r;
    end
  end

  // Handshake: the input register refills whenever its beat moves on; the
  // result register refills whenever it is empty or being taken.
  assign out_free     = !out_vld_r || out_ch.ready;
  assign drain_emit   = (drain_cnt_r != '0) && out_free;
  assign s1_take      = s1_vld_r && out_free && (drain_cnt_r == '0);
  assign in_ch.ready  = !s1_vld_r || s1_take;
  assign cfg_ch.ready = 1'b1;

  // Threshold bands: every element compares in parallel, first hit wins
  always_comb begin
    thr_lhs   = PROD_BITS'(s1_work_r) * PROD_BITS'(pes);
    thr_hit   = '0;
    thr_pe    = '0;
    thr_rhs   = '0;
    for (int j = 0; j < MAX_PES; j++) begin
      thr_rhs    = PROD_BITS'(col_count_r) * PROD_BITS'(j + 1);
      thr_hit[j] = (PES_BITS'(j) < pes) && (thr_lhs <= thr_rhs);
    end
    for (int j = MAX_PES - 1; j >= 0; j--) begin
      if (thr_hit[j]) begin
        thr_pe = PE_BITS'(j);
      end
    end
    thr_found = |thr_hit;
  end

  // Round robin: restart at element 0 when the pointer lies past pe_count
  always_comb begin
    if ({1'b0, rr_element_r} >= pes) begin
      rr_cur      = '0;
      rr_used_cur = '0;
    end else begin
      rr_cur      = rr_element_r;
      rr_used_cur = rr_used_r;
    end
    rr_weight = weights_r[{rr_cur, 2'b00} +: WGT_BITS];
    if (rr_weight == '0) begin
      rr_weight = WGT_BITS'(1);
    end
    rr_used_inc = rr_used_cur + WGT_BITS'(1);
    rr_step     = ({1'b0, rr_cur} + PES_BITS'(1) >= pes) ? '0 : rr_cur + PE_BITS'(1);
  end

  // Group pointer for the beat being drained
  always_comb begin
    ge_cur  = ({1'b0, group_element_r} >= pes) ? '0 : group_element_r;
    ge_step = ({1'b0, ge_cur} + PES_BITS'(1) >= pes) ? '0 : ge_cur + PE_BITS'(1);
  end

  // Sorted insert: the store stays ascending, a new task goes after its equals.
  // Slots at or past the fill level count as greater than the new task.
  always_comb begin
    for (int i = 0; i < MAX_GROUP; i++) begin
      ins_gt[i] = (FILL_BITS'(i) >= group_fill_r) || (group_store_r[i] > s1_work_r);
    end
    for (int i = 0; i < MAX_GROUP; i++) begin
      if (!ins_gt[i]) begin
        group_store_nxt[i] = group_store_r[i];
      end else if (i > 0 && ins_gt[(i > 0) ? i - 1 : 0]) begin
        group_store_nxt[i] = group_store_r[(i > 0) ? i - 1 : 0];
      end else begin
        group_store_nxt[i] = s1_work_r;
      end
    end
    fill_inc = group_fill_r + FILL_BITS'(1);
  end

  // Main next-state logic
  always_comb begin
    s1_vld_nxt        = s1_take ? 1'b0 : s1_vld_r;
    out_vld_nxt       = out_ch.ready ? 1'b0 : out_vld_r;
    out_pe_nxt        = out_pe_r;
    out_work_nxt      = out_work_r;
    out_drop_nxt      = out_drop_r;
    out_last_nxt      = out_last_r;
    rr_element_nxt    = rr_element_r;
    rr_used_nxt       = rr_used_r;
    group_fill_nxt    = group_fill_r;
    group_element_nxt = group_element_r;
    drain_cnt_nxt     = drain_cnt_r;
    drain_idx_nxt     = drain_idx_r;
    drain_clr_nxt     = drain_clr_r;
    store_we          = 1'b0;

    if (in_ch.valid && in_ch.ready) begin
      s1_vld_nxt = 1'b1;
    end

    // Hand the next sorted task of a completed group to the result register
    if (drain_emit) begin
      out_vld_nxt   = 1'b1;
      out_pe_nxt    = ge_cur;
      out_work_nxt  = group_store_r[drain_idx_r];
      out_drop_nxt  = 1'b0;
      out_last_nxt  = (drain_cnt_r == FILL_BITS'(1));
      drain_cnt_nxt = drain_cnt_r - FILL_BITS'(1);
      drain_idx_nxt = drain_idx_r + GIDX_BITS'(1);
      group_element_nxt = (drain_cnt_r == FILL_BITS'(1) && drain_clr_r) ? '0 : ge_step;
    end

    if (s1_take) begin
      case (mode_r)
        MODE_THRESH: begin
          out_vld_nxt  = 1'b1;
          out_pe_nxt   = thr_found ? thr_pe : '0;
          out_work_nxt = s1_work_r;
          out_drop_nxt = !thr_found;
          out_last_nxt = 1'b1;
        end
        MODE_WRR: begin
          out_vld_nxt  = 1'b1;
          out_pe_nxt   = rr_cur;
          out_work_nxt = s1_work_r;
          out_drop_nxt = 1'b0;
          out_last_nxt = 1'b1;
          if (rr_used_inc >= rr_weight) begin
            rr_used_nxt    = '0;
            rr_element_nxt = rr_step;
          end else begin
            rr_used_nxt    = rr_used_inc;
            rr_element_nxt = rr_cur;
          end
        end
        MODE_GROUP: begin
          if (group_fill_r < FILL_BITS'(MAX_GROUP)) begin
            store_we       = 1'b1;
            group_fill_nxt = fill_inc;
          end
          // Group complete or row over: start the drain of the sorted store
          if ((store_we ? fill_inc : group_fill_r) >= FILL_BITS'(gs) || s1_row_end_r) begin
            drain_cnt_nxt  = store_we ? fill_inc : group_fill_r;
            drain_idx_nxt  = '0;
            drain_clr_nxt  = s1_row_end_r;
            group_fill_nxt = '0;
          end
        end
        default: begin
        end
      endcase
      if (s1_row_end_r) begin
        rr_element_nxt = '0;
        rr_used_nxt    = '0;
        group_fill_nxt = '0;
        // In group mode the element pointer clears once the drain is done
        if (mode_r != MODE_GROUP) begin
          group_element_nxt = '0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= mode_t'(MODE_RST);
      pe_count_r      <= PES_RST;
      group_size_r    <= GSIZE_RST;
      col_count_r     <= COL_RST;
      weights_r       <= {WGT_RST, WGT_RST};
      s1_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      rr_element_r    <= '0;
      rr_used_r       <= '0;
      group_fill_r    <= '0;
      group_element_r <= '0;
      drain_cnt_r     <= '0;
      drain_idx_r     <= '0;
      drain_clr_r     <= 1'b0;
    end else begin
      s1_vld_r        <= s1_vld_nxt;
      out_vld_r       <= out_vld_nxt;
      rr_element_r    <= rr_element_nxt;
      rr_used_r       <= rr_used_nxt;
      group_fill_r    <= group_fill_nxt;
      group_element_r <= group_element_nxt;
      drain_cnt_r     <= drain_cnt_nxt;
      drain_idx_r     <= drain_idx_nxt;
      drain_clr_r     <= drain_clr_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_MODE:       mode_r       <= mode_t'(cfg_ch.data[1:0]);
          CFG_PE_COUNT:   pe_count_r   <= cfg_ch.data[PES_BITS-1:0];
          CFG_GROUP_SIZE: group_size_r <= cfg_ch.data[GSIZE_BITS-1:0];
          CFG_COL_COUNT:  col_count_r  <= cfg_ch.data[COL_BITS-1:0];
          CFG_WEIGHTS_LO: weights_r[CFG_DATA_BITS-1:0] <= cfg_ch.data;
          CFG_WEIGHTS_HI: weights_r[2*CFG_DATA_BITS-1:CFG_DATA_BITS] <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_work_r    <= in_ch.work;
      s1_row_end_r <= in_ch.row_end;
    end
    out_pe_r   <= out_pe_nxt;
    out_work_r <= out_work_nxt;
    out_drop_r <= out_drop_nxt;
    out_last_r <= out_last_nxt;
    if (store_we) begin
      for (int i = 0; i < MAX_GROUP; i++) begin
        group_store_r[i] <= group_store_nxt[i];
      end
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.pe_index  = out_pe_r;
  assign out_ch.task_work = out_work_r;
  assign out_ch.dropped   = out_drop_r;
  assign out_ch.run_last  = out_last_r;

  // A full group always flushes, so the fill level never reaches the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    group_fill_r < FILL_BITS'(MAX_GROUP))
    else $error("group fill level reached store depth");

  // No task beat is taken from the input register while a group drains
  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_cnt_r != '0) |-> !s1_take)
    else $error("task taken during group drain");

  // The final drained beat of a group closes the run
  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_emit && drain_cnt_r == FILL_BITS'(1)) |=> (out_vld_r && out_last_r))
    else $error("group drain did not end with run_last");

  // Threshold and round robin beats give exactly one closing result
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && (mode_r == MODE_THRESH || mode_r == MODE_WRR))
      |=> (out_vld_r && out_last_r))
    else $error("single-result mode produced no closing result");

endmodule
